>>> hw/rtl/utf8e_pkg.sv
`default_nettype none

package utf8e_pkg;

    // code point width
    localparam int CP_W = 21;
    typedef logic [CP_W-1:0] t_cp;

    // byte classes found by the front end
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_AMP,
        CLS_SEMI,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_INVALID
    } t_byte_class;

    // decoder mode
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_UTF8,
        MODE_ENTITY
    } t_dec_mode;

    // back end sequencer
    typedef enum logic {
        ST_WAIT,
        ST_RUN
    } t_back_state;

    // case_mode register codes
    localparam logic [1:0] CASE_NONE    = 2'd0;
    localparam logic [1:0] CASE_UPPER   = 2'd1;
    localparam logic [1:0] CASE_LOWER   = 2'd2;
    localparam logic [1:0] CASE_CAPITAL = 2'd3;

    localparam logic [7:0] CHAR_AMP  = 8'h26;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam t_cp        CP_AMP    = 21'h26;
    localparam t_cp        CP_QMARK  = 21'h3F;

    // entity names, left aligned, one byte per character
    localparam int NUM_NAMES = 6;
    localparam int NAME_MAX  = 4;
    localparam logic [NAME_MAX*8-1:0] NAME_TEXT [NUM_NAMES] = '{
        32'h6C74_0000,  // lt
        32'h6774_0000,  // gt
        32'h616D_7000,  // amp
        32'h6E62_7370,  // nbsp
        32'h7175_6F74,  // quot
        32'h6170_6F73   // apos
    };
    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
        3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam t_cp NAME_CP [NUM_NAMES] = '{
        21'd60, 21'd62, 21'd38, 21'd160, 21'd34, 21'd39
    };

    typedef struct packed {
        logic [7:0]  text_byte;
        t_byte_class cls;
        logic        word_start;
        logic        end_of_string;
    } t_in_item;

    typedef struct packed {
        t_cp  code_point;
        logic substituted;
        logic last_of_run;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_byte_class classify(logic [7:0] b);
        t_byte_class c;
        if (b == CHAR_AMP) begin
            c = CLS_AMP;
        end else if (b == CHAR_SEMI) begin
            c = CLS_SEMI;
        end else if (!b[7]) begin
            c = CLS_ASCII;
        end else if (b[7:5] == 3'b110) begin
            c = CLS_LEAD2;
        end else if (b[7:4] == 4'b1110) begin
            c = CLS_LEAD3;
        end else if (b[7:3] == 5'b11110) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_INVALID;
        end
        return c;
    endfunction

    function automatic logic [7:0] name_char(int k, logic [1:0] idx);
        logic [NAME_MAX*8-1:0] sh;
        sh = NAME_TEXT[k] << {idx, 3'b000};
        return sh[NAME_MAX*8-1 -: 8];
    endfunction

    function automatic t_cp apply_case(t_cp cp, logic [1:0] mode, logic first);
        t_cp r;
        r = cp;
        if (mode == CASE_UPPER || (mode == CASE_CAPITAL && first)) begin
            if (cp inside {[21'h61:21'h7A]}) begin
                r = cp - 21'd32;
            end
        end else if (mode == CASE_LOWER) begin
            if (cp inside {[21'h41:21'h5A]}) begin
                r = cp + 21'd32;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/utf8e_fifo.sv
`default_nettype none

module utf8e_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [WIDTH-1:0]     i_data,
    input  wire logic                 i_pop,
    output logic [WIDTH-1:0]          o_data,
    output utf8e_pkg::t_q_status      o_status
);
    import utf8e_pkg::*;

    // two-entry queue
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/utf8e_front.sv
`default_nettype none

module utf8e_front (
    input  wire logic                 i_valid,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_word_start,
    input  wire logic                 i_end_of_string,
    input  wire utf8e_pkg::t_q_status i_q_status,
    output logic                      o_stall,
    output logic                      o_push,
    output utf8e_pkg::t_in_item       o_item
);
    import utf8e_pkg::*;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // tag each byte once, replays reuse the tag
    always_comb begin
        o_item.text_byte     = i_text_byte;
        o_item.cls           = classify(i_text_byte);
        o_item.word_start    = i_word_start;
        o_item.end_of_string = i_end_of_string;
    end

endmodule

`default_nettype wire

>>> hw/rtl/utf8e_back.sv
`default_nettype none

module utf8e_back #(
    parameter int ENTITY_LOOKAHEAD = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire utf8e_pkg::t_in_item  i_item,
    input  wire utf8e_pkg::t_q_status i_in_status,
    output logic                      o_item_pop,
    input  wire logic [1:0]           i_case_mode,
    input  wire utf8e_pkg::t_q_status i_out_status,
    output logic                      o_out_push,
    output utf8e_pkg::t_out_item      o_out_item
);
    import utf8e_pkg::*;

    localparam int RING_DEPTH = 2 ** $clog2(ENTITY_LOOKAHEAD + 2);
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int ELEN_W     = $clog2(ENTITY_LOOKAHEAD + 1);

    typedef struct packed {
        logic [7:0]  text_byte;
        t_byte_class cls;
    } t_ring_entry;

    // byte log: fresh bytes are written here, failed lookaheads replay from it
    t_ring_entry          r_ring [RING_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr,    n_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr,    n_rd_ptr;
    logic [PTR_W-1:0]     r_start_ptr, n_start_ptr;

    t_back_state          r_state,  n_state;
    t_dec_mode            r_mode,   n_mode;
    logic [1:0]           r_pending, n_pending;
    t_cp                  r_acc,    n_acc;
    logic [ELEN_W-1:0]    r_elen,   n_elen;
    logic                 r_first,  n_first;
    logic [NUM_NAMES-1:0] r_match,  n_match;
    logic                 r_eos,    n_eos;
    logic                 r_hold_vld, n_hold_vld;
    t_cp                  r_hold_cp,  n_hold_cp;
    logic                 r_hold_sub, n_hold_sub;

    t_ring_entry          ring_rd;
    logic                 ring_we;
    logic                 advance;
    logic                 byte_go;
    logic [7:0]           cur_byte;
    t_byte_class          cur_cls;
    logic                 cur_first;
    logic                 emit_vld;
    t_cp                  emit_cp;
    logic                 emit_sub;
    logic                 end_step;
    t_cp                  acc_shift;
    logic                 name_hit;
    t_cp                  name_cp;

    assign ring_rd   = r_ring[r_rd_ptr];
    assign acc_shift = {r_acc[CP_W-7:0], cur_byte[5:0]};

    // name lookup from the running prefix match flags
    always_comb begin
        name_hit = 1'b0;
        name_cp  = '0;
        for (int k = 0; k < NUM_NAMES; k++) begin
            if (r_match[k] && r_elen == ELEN_W'(NAME_LEN[k])) begin
                name_hit = 1'b1;
                name_cp  = NAME_CP[k];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_pending   = r_pending;
        n_acc       = r_acc;
        n_elen      = r_elen;
        n_first     = r_first;
        n_match     = r_match;
        n_eos       = r_eos;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_start_ptr = r_start_ptr;
        n_hold_vld  = r_hold_vld;
        n_hold_cp   = r_hold_cp;
        n_hold_sub  = r_hold_sub;
        ring_we     = 1'b0;
        o_item_pop  = 1'b0;
        byte_go     = 1'b0;
        cur_byte    = i_item.text_byte;
        cur_cls     = i_item.cls;
        cur_first   = 1'b0;
        emit_vld    = 1'b0;
        emit_cp     = '0;
        emit_sub    = 1'b0;
        end_step    = 1'b0;
        o_out_push  = 1'b0;
        o_out_item  = '0;
        advance     = !i_out_status.full;

        case (r_state)
            ST_WAIT: begin
                if (advance && !i_in_status.empty) begin
                    byte_go    = 1'b1;
                    o_item_pop = 1'b1;
                    ring_we    = 1'b1;
                    n_wr_ptr   = r_wr_ptr + PTR_W'(1);
                    cur_first  = i_item.word_start;
                    n_eos      = i_item.end_of_string;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    if (r_rd_ptr != r_wr_ptr) begin
                        byte_go  = 1'b1;
                        cur_byte = ring_rd.text_byte;
                        cur_cls  = ring_rd.cls;
                    end else if (r_eos && r_mode == MODE_UTF8) begin
                        emit_vld  = 1'b1;
                        emit_cp   = CP_QMARK;
                        emit_sub  = 1'b1;
                        n_mode    = MODE_IDLE;
                        n_pending = 2'd0;
                        n_acc     = '0;
                    end else if (r_eos && r_mode == MODE_ENTITY) begin
                        emit_vld = 1'b1;
                        emit_cp  = apply_case(CP_AMP, i_case_mode, r_first);
                        n_rd_ptr = r_start_ptr;
                        n_mode   = MODE_IDLE;
                        n_elen   = '0;
                    end else begin
                        end_step = 1'b1;
                        if (r_eos) begin
                            n_first = 1'b0;
                        end
                        n_state = ST_WAIT;
                    end
                end
            end
            default: begin
                n_state = ST_WAIT;
            end
        endcase

        if (byte_go) begin
            n_rd_ptr = r_rd_ptr + PTR_W'(1);
            case (r_mode)
                MODE_UTF8: begin
                    n_acc     = acc_shift;
                    n_pending = r_pending - 2'd1;
                    if (r_pending == 2'd1) begin
                        emit_vld = 1'b1;
                        emit_cp  = apply_case(acc_shift, i_case_mode, r_first);
                        n_mode   = MODE_IDLE;
                    end
                end
                MODE_ENTITY: begin
                    if (cur_cls == CLS_SEMI && name_hit) begin
                        emit_vld = 1'b1;
                        emit_cp  = apply_case(name_cp, i_case_mode, r_first);
                        n_elen   = '0;
                        n_mode   = MODE_IDLE;
                    end else if (cur_cls != CLS_SEMI && r_elen < ELEN_W'(ENTITY_LOOKAHEAD)) begin
                        n_elen = r_elen + ELEN_W'(1);
                        for (int k = 0; k < NUM_NAMES; k++) begin
                            n_match[k] = r_match[k] && (r_elen < ELEN_W'(NAME_LEN[k]))
                                && (cur_byte == name_char(k, r_elen[1:0]));
                        end
                    end else begin
                        // failed lookahead: '&' then replay everything after it
                        emit_vld = 1'b1;
                        emit_cp  = apply_case(CP_AMP, i_case_mode, r_first);
                        n_rd_ptr = r_start_ptr;
                        n_elen   = '0;
                        n_mode   = MODE_IDLE;
                    end
                end
                default: begin
                    case (cur_cls)
                        CLS_AMP: begin
                            n_mode      = MODE_ENTITY;
                            n_elen      = '0;
                            n_first     = cur_first;
                            n_start_ptr = r_rd_ptr + PTR_W'(1);
                            n_match     = '1;
                        end
                        CLS_ASCII, CLS_SEMI: begin
                            emit_vld = 1'b1;
                            emit_cp  = apply_case({{(CP_W-8){1'b0}}, cur_byte},
                                                  i_case_mode, cur_first);
                        end
                        CLS_LEAD2: begin
                            n_acc      = '0;
                            n_acc[4:0] = cur_byte[4:0];
                            n_pending  = 2'd1;
                            n_first    = cur_first;
                            n_mode     = MODE_UTF8;
                        end
                        CLS_LEAD3: begin
                            n_acc      = '0;
                            n_acc[3:0] = cur_byte[3:0];
                            n_pending  = 2'd2;
                            n_first    = cur_first;
                            n_mode     = MODE_UTF8;
                        end
                        CLS_LEAD4: begin
                            n_acc      = '0;
                            n_acc[2:0] = cur_byte[2:0];
                            n_pending  = 2'd3;
                            n_first    = cur_first;
                            n_mode     = MODE_UTF8;
                        end
                        default: begin
                            emit_vld = 1'b1;
                            emit_cp  = CP_QMARK;
                            emit_sub = 1'b1;
                        end
                    endcase
                end
            endcase
        end

        // one result is held back so the last one of a byte can be flagged
        if (emit_vld) begin
            if (r_hold_vld) begin
                o_out_push             = 1'b1;
                o_out_item.code_point  = r_hold_cp;
                o_out_item.substituted = r_hold_sub;
                o_out_item.last_of_run = 1'b0;
            end
            n_hold_vld = 1'b1;
            n_hold_cp  = emit_cp;
            n_hold_sub = emit_sub;
        end else if (end_step && r_hold_vld) begin
            o_out_push             = 1'b1;
            o_out_item.code_point  = r_hold_cp;
            o_out_item.substituted = r_hold_sub;
            o_out_item.last_of_run = 1'b1;
            n_hold_vld             = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_wr_ptr] <= '{text_byte: i_item.text_byte, cls: i_item.cls};
        end
        r_hold_cp  <= n_hold_cp;
        r_hold_sub <= n_hold_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_mode      <= MODE_IDLE;
            r_pending   <= 2'd0;
            r_acc       <= '0;
            r_elen      <= '0;
            r_first     <= 1'b0;
            r_match     <= '0;
            r_eos       <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_start_ptr <= '0;
            r_hold_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_pending   <= n_pending;
            r_acc       <= n_acc;
            r_elen      <= n_elen;
            r_first     <= n_first;
            r_match     <= n_match;
            r_eos       <= n_eos;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_start_ptr <= n_start_ptr;
            r_hold_vld  <= n_hold_vld;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/utf8_entity_char_decoder_core.sv
// UTF-8 text decoder with HTML entity recognition and an ASCII case transform.
// Each input transfer carries one text byte with word_start and end_of_string
// flags; each output transfer carries one code point, a substituted flag (set
// when '?' stands for a cut-off or invalid sequence) and last_of_run, set on
// the final result caused by that input byte. A byte may cause no result
// (inside a UTF-8 sequence or an entity lookahead) or several (a failed
// lookahead gives '&' and then the buffered bytes decoded again). The front
// end tags each byte with its class and queues it; the back end is a single
// byte-wide decode engine that logs bytes in a small ring so that a failed
// lookahead replays from it. An ordinary byte takes a decode step and a
// closing step that flags the last result; each replayed byte adds a decode
// step; at end of string a cut-off UTF-8 sequence or each failed lookahead
// adds a further step. The engine takes a new byte only once the last is done;
// while it replays, input is held off once the two-entry input queue is full.
// case_mode is written through i_cfg_we / i_cfg_wdata: 0 none, 1 upper,
// 2 lower, 3 upper on word start.
`default_nettype none

module utf8_entity_char_decoder_core #(
    parameter int ENTITY_LOOKAHEAD = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    // byte input
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_word_start,
    input  wire logic        i_end_of_string,
    // code point output
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [20:0]      o_code_point,
    output logic             o_substituted,
    output logic             o_last_of_run
);
    import utf8e_pkg::*;

    logic [1:0]  r_case_mode;

    t_q_status   in_q_status;
    t_q_status   out_q_status;
    logic        front_push;
    t_in_item    front_item;
    logic [$bits(t_in_item)-1:0]  in_q_data;
    logic [$bits(t_out_item)-1:0] out_q_data;
    t_in_item    back_item;
    logic        back_pop;
    logic        back_push;
    t_out_item   back_out;
    t_out_item   out_item;

    // case mode register; the user must write it only while the block is quiet, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_mode <= CASE_NONE;
        end else if (i_cfg_we) begin
            r_case_mode <= i_cfg_wdata;
        end
    end

    // front end: classify and queue incoming bytes
    utf8e_front u_front (
        .i_valid         (i_valid),
        .i_text_byte     (i_text_byte),
        .i_word_start    (i_word_start),
        .i_end_of_string (i_end_of_string),
        .i_q_status      (in_q_status),
        .o_stall         (o_stall),
        .o_push          (front_push),
        .o_item          (front_item)
    );

    // queue between front and back end
    utf8e_fifo #(
        .WIDTH ($bits(t_in_item))
    ) u_in_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_data   (front_item),
        .i_pop    (back_pop),
        .o_data   (in_q_data),
        .o_status (in_q_status)
    );

    assign back_item = t_in_item'(in_q_data);

    // back end: decode engine with replay ring
    utf8e_back #(
        .ENTITY_LOOKAHEAD (ENTITY_LOOKAHEAD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (back_item),
        .i_in_status  (in_q_status),
        .o_item_pop   (back_pop),
        .i_case_mode  (r_case_mode),
        .i_out_status (out_q_status),
        .o_out_push   (back_push),
        .o_out_item   (back_out)
    );

    // result queue, lets the engine run on while the sink stalls until the queue is full
    utf8e_fifo #(
        .WIDTH ($bits(t_out_item))
    ) u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (back_push),
        .i_data   (back_out),
        .i_pop    (o_valid && !i_stall),
        .o_data   (out_q_data),
        .o_status (out_q_status)
    );

    assign out_item      = t_out_item'(out_q_data);
    assign o_valid       = !out_q_status.empty;
    assign o_code_point  = out_item.code_point;
    assign o_substituted = out_item.substituted;
    assign o_last_of_run = out_item.last_of_run;

endmodule

`default_nettype wire

>>> hw/rtl/utf8e_checker.sv
`default_nettype none

module utf8e_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic [1:0]  i_cfg_wdata,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [20:0] o_code_point,
    input wire logic        o_substituted,
    input wire logic        o_last_of_run
);
    import utf8e_pkg::*;

    logic [1:0] r_seen_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_mode <= CASE_NONE;
        end else if (i_cfg_we) begin
            r_seen_mode <= i_cfg_wdata;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_code_point) && $stable(o_substituted)
            && $stable(o_last_of_run))
        else $error("stalled output payload changed");

    a_sub_is_qmark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_substituted |-> o_code_point == CP_QMARK)
        else $error("substituted result is not a question mark");

    a_lower_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_seen_mode == CASE_LOWER
            |-> !(o_code_point >= 21'h41 && o_code_point <= 21'h5A))
        else $error("uppercase letter seen in lowercase mode");

endmodule

bind utf8_entity_char_decoder_core utf8e_checker u_checker (.*);

`default_nettype wire

>>> tb/utf8_decode_checker.sv
module utf8_decode_checker #(
    parameter int LOOKAHEAD = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_word_start,
    input  wire logic        i_end_of_string,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [20:0] i_code_point,
    input  wire logic        i_substituted,
    input  wire logic        i_last_of_run,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    import utf8e_pkg::*;

    localparam int MAX_RUN = LOOKAHEAD + 2;

    // decoder state as the block should hold it
    logic [1:0] case_sel;
    t_dec_mode  dec_mode;
    logic [1:0] cont_left;
    t_cp        cp_acc;
    logic [7:0] ent_text [LOOKAHEAD];
    int         ent_len;
    logic       word_first;

    logic [7:0] replay_byte [$];
    logic       replay_fresh [$];
    t_out_item  run_out [$];
    t_out_item  cp_expected [$];
    t_out_item  want;

    int fails     = 0;
    int checked_n = 0;
    int waiting   = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;
    assign o_checked    = checked_n;

    function automatic t_cp fold_case(t_cp cp, logic first);
        if (case_sel == CASE_UPPER || (case_sel == CASE_CAPITAL && first)) begin
            if (cp >= 21'h61 && cp <= 21'h7A) return cp - 21'd32;
        end else if (case_sel == CASE_LOWER) begin
            if (cp >= 21'h41 && cp <= 21'h5A) return cp + 21'd32;
        end
        return cp;
    endfunction

    function automatic void push_cp(t_cp cp, logic sub);
        t_out_item r;
        r.code_point  = cp;
        r.substituted = sub;
        r.last_of_run = 1'b0;
        if (run_out.size() < MAX_RUN) run_out.insert(run_out.size(), r);
    endfunction

    function automatic t_cp entity_code();
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < ent_len) w[31-8*i -: 8] = ent_text[i];
        end
        if (ent_len == 2 && w[31:16] == "lt") return 21'd60;
        if (ent_len == 2 && w[31:16] == "gt") return 21'd62;
        if (ent_len == 3 && w[31:8] == "amp") return 21'd38;
        if (ent_len == 4 && w == "nbsp") return 21'd160;
        if (ent_len == 4 && w == "quot") return 21'd34;
        if (ent_len == 4 && w == "apos") return 21'd39;
        return '0;
    endfunction

    // failed lookahead: '&' out, then buffered bytes go back in front of the rest
    function automatic void lookahead_fail(logic with_cur, logic [7:0] cur);
        logic [7:0] again [$];
        push_cp(fold_case(CP_AMP, word_first), 1'b0);
        for (int i = 0; i < ent_len; i++) again.insert(again.size(), ent_text[i]);
        if (with_cur) again.insert(again.size(), cur);
        foreach (replay_byte[i]) again.insert(again.size(), replay_byte[i]);
        replay_byte = again;
        replay_fresh.delete();
        foreach (again[i]) replay_fresh.insert(replay_fresh.size(), 1'b0);
        ent_len  = 0;
        dec_mode = MODE_IDLE;
    endfunction

    function automatic void decode_one(logic [7:0] b, logic first);
        t_cp hit;
        case (dec_mode)
            MODE_UTF8: begin
                cp_acc = {cp_acc[14:0], b[5:0]};
                if (cont_left != 0) cont_left--;
                if (cont_left == 0) begin
                    push_cp(fold_case(cp_acc, word_first), 1'b0);
                    dec_mode = MODE_IDLE;
                end
            end
            MODE_ENTITY: begin
                if (b == CHAR_SEMI) begin
                    hit = entity_code();
                    if (hit != 0) begin
                        push_cp(fold_case(hit, word_first), 1'b0);
                        ent_len  = 0;
                        dec_mode = MODE_IDLE;
                    end else begin
                        lookahead_fail(1'b1, b);
                    end
                end else if (ent_len < LOOKAHEAD) begin
                    ent_text[ent_len] = b;
                    ent_len++;
                end else begin
                    lookahead_fail(1'b1, b);
                end
            end
            default: begin
                if (b == CHAR_AMP) begin
                    dec_mode   = MODE_ENTITY;
                    ent_len    = 0;
                    word_first = first;
                end else if (!b[7]) begin
                    push_cp(fold_case({13'd0, b}, first), 1'b0);
                end else if (b[7:5] == 3'b110) begin
                    cp_acc     = {16'd0, b[4:0]};
                    cont_left  = 2'd1;
                    word_first = first;
                    dec_mode   = MODE_UTF8;
                end else if (b[7:4] == 4'b1110) begin
                    cp_acc     = {17'd0, b[3:0]};
                    cont_left  = 2'd2;
                    word_first = first;
                    dec_mode   = MODE_UTF8;
                end else if (b[7:3] == 5'b11110) begin
                    cp_acc     = {18'd0, b[2:0]};
                    cont_left  = 2'd3;
                    word_first = first;
                    dec_mode   = MODE_UTF8;
                end else begin
                    push_cp(CP_QMARK, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void drain(logic ws);
        logic [7:0] b;
        logic       fr;
        while (replay_byte.size() > 0) begin
            b  = replay_byte.pop_front();
            fr = replay_fresh.pop_front();
            decode_one(b, fr ? ws : 1'b0);
        end
    endfunction

    function automatic void predict_transfer(logic [7:0] b, logic ws, logic eos);
        t_out_item r;
        run_out.delete();
        replay_byte.delete();
        replay_fresh.delete();
        replay_byte.insert(0, b);
        replay_fresh.insert(0, 1'b1);
        drain(ws);
        if (eos) begin
            while (dec_mode != MODE_IDLE) begin
                if (dec_mode == MODE_UTF8) begin
                    push_cp(CP_QMARK, 1'b1);
                    cont_left = '0;
                    cp_acc    = '0;
                    dec_mode  = MODE_IDLE;
                end else begin
                    lookahead_fail(1'b0, 8'h00);
                    drain(ws);
                end
            end
            word_first = 1'b0;
        end
        if (run_out.size() > 0) begin
            r = run_out[run_out.size() - 1];
            r.last_of_run = 1'b1;
            run_out[run_out.size() - 1] = r;
        end
        foreach (run_out[i]) cp_expected.insert(cp_expected.size(), run_out[i]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            case_sel   = CASE_NONE;
            dec_mode   = MODE_IDLE;
            cont_left  = '0;
            cp_acc     = '0;
            ent_len    = 0;
            word_first = 1'b0;
            cp_expected.delete();
        end else begin
            if (i_cfg_we) case_sel = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                predict_transfer(i_text_byte, i_word_start, i_end_of_string);
            end
            if (i_out_valid && !i_out_stall) begin
                if (cp_expected.size() == 0) begin
                    $display("%0t: unexpected code point: expected none, got cp %h sub %b last %b",
                             $time, i_code_point, i_substituted, i_last_of_run);
                    fails++;
                end else begin
                    want = cp_expected.pop_front();
                    if (want.code_point != i_code_point
                        || want.substituted != i_substituted
                        || want.last_of_run != i_last_of_run) begin
                        $display({"%0t: mismatch: expected cp %h sub %b last %b,",
                                  " got cp %h sub %b last %b"},
                                 $time, want.code_point, want.substituted,
                                 want.last_of_run,
                                 i_code_point, i_substituted, i_last_of_run);
                        fails++;
                    end
                    checked_n++;
                end
            end
        end
        waiting = cp_expected.size();
    end

endmodule

>>> tb/utf8_entity_char_decoder_core_test.sv
module utf8_entity_char_decoder_core_test;
    import utf8e_pkg::*;

    localparam int LOOKAHEAD     = 6;
    localparam int PHASE_BYTES   = 40;    // input bytes per case-mode phase
    localparam int HOLD_CYCLES   = 200;   // long output hold-off
    localparam int SETTLE_CYCLES = 40;    // engine drain time before a config write
    localparam int IDLE_LIMIT    = 3000;  // cycles with no transfer on either side

    // phase styles
    localparam int PHASE_PLAIN = 0;
    localparam int PHASE_HOLD  = 1;
    localparam int PHASE_QUIET = 2;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_wdata     = CASE_NONE;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte     = 8'h00;
    logic        word_start    = 1'b0;
    logic        end_of_string = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [20:0] code_point;
    logic        substituted;
    logic        last_of_run;

    int fail_count;
    int pending;
    int checked;

    int bytes_sent  = 0;
    int phase_bytes = 0;
    int case_writes = 0;
    int idle_cycles = 0;

    // handshake between the sender and the receiver process
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;
    bit rx_quiet    = 1'b0;
    bit tx_no_gap   = 1'b0;

    // one generated text unit: bytes, per-byte word start, end of string on the last
    logic [7:0] unit_bytes [$];
    logic       unit_ws [$];
    logic       unit_eos;

    string entity_names [6] = '{"lt", "gt", "amp", "nbsp", "quot", "apos"};

    // opening directed bytes, each {end_of_string, word_start, byte}
    logic [9:0] opening [23] = '{
        {2'b01, 8'h00},        // zero byte is an ordinary character
        {2'b00, 8'h7F},        // top of ascii
        {2'b00, 8'hFF},        // invalid lead
        {2'b00, 8'h80},        // stray continuation as lead
        {2'b01, 8'hC3},        // two-byte sequence
        {2'b00, 8'hA9},
        {2'b00, 8'hF4},        // four-byte sequence, word start on a continuation
        {2'b01, 8'h8F},
        {2'b00, 8'hBF},
        {2'b00, 8'hBF},
        {2'b00, 8'hF8},        // just past the four-byte lead mask
        {2'b01, CHAR_AMP},     // a named entity
        {2'b00, 8'h61},
        {2'b00, 8'h6D},
        {2'b00, 8'h70},
        {2'b00, CHAR_SEMI},
        {2'b00, 8'hE2},        // three-byte sequence cut by end of string
        {2'b10, 8'h82},
        {2'b00, CHAR_AMP},     // lookahead cut by end of string
        {2'b10, 8'h71},
        {2'b00, CHAR_AMP},     // empty name
        {2'b00, CHAR_SEMI},
        {2'b11, 8'h7A}
    };

    utf8_entity_char_decoder_core #(
        .ENTITY_LOOKAHEAD(LOOKAHEAD)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_text_byte    (text_byte),
        .i_word_start   (word_start),
        .i_end_of_string(end_of_string),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_code_point   (code_point),
        .o_substituted  (substituted),
        .o_last_of_run  (last_of_run)
    );

    utf8_decode_checker #(
        .LOOKAHEAD(LOOKAHEAD)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_text_byte    (text_byte),
        .i_word_start   (word_start),
        .i_end_of_string(end_of_string),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_code_point   (code_point),
        .i_substituted  (substituted),
        .i_last_of_run  (last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog: too long without any transfer means the block hung
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random stall runs, a quiet stretch, and one long hold-off on request
    initial begin
        int pick;
        int span;
        @(posedge clk);
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end else begin
                if (rx_quiet) begin
                    out_stall <= 1'b0;
                    span = 1;
                end else if (pick < 60) begin
                    out_stall <= 1'b0;
                    span = $urandom_range(1, 8);
                end else if (pick < 94) begin
                    out_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    span = $urandom_range(10, 40);
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    // sender gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (tx_no_gap || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one byte transfer; valid stays high on return so back-to-back bytes need no gap
    task automatic send_byte(logic [7:0] b, logic ws, logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        text_byte     <= b;
        word_start    <= ws;
        end_of_string <= eos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
        phase_bytes++;
    endtask

    // input quiet until every expected code point is out and the engine has settled
    task automatic wait_settled();
        in_valid <= 1'b0;
        do begin
            wait (pending == 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end while (pending != 0);
    endtask

    task automatic set_case(logic [1:0] mode);
        wait_settled();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        case_writes++;
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1) == 1) c = c - 8'h20;
        return c;
    endfunction

    // content for a lookahead: letters, with separators, ampersands and raw bytes mixed in
    function automatic logic [7:0] lookahead_byte();
        int p;
        p = $urandom_range(0, 9);
        if (p < 6) return pick_letter();
        if (p == 6) return CHAR_SEMI;
        if (p == 7) return CHAR_AMP;
        return 8'($urandom());
    endfunction

    // append one byte to the unit under construction
    function automatic void put_byte(logic [7:0] b);
        unit_bytes.insert(unit_bytes.size(), b);
    endfunction

    function automatic void build_unit();
        int         kind;
        int         n;
        int         conts;
        string      nm;
        logic [7:0] b;
        unit_bytes.delete();
        unit_ws.delete();
        unit_eos = ($urandom_range(0, 99) < 15);
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            // plain word, maybe followed by a space
            n = $urandom_range(1, 6);
            repeat (n) put_byte(pick_letter());
            if ($urandom_range(0, 2) == 0) put_byte(8'h20);
        end else if (kind < 50) begin
            // named entity, now and then with one character spoiled
            nm = entity_names[$urandom_range(0, 5)];
            put_byte(CHAR_AMP);
            for (int i = 0; i < nm.len(); i++) put_byte(nm[i]);
            if ($urandom_range(0, 4) == 0) begin
                unit_bytes[$urandom_range(1, nm.len())] = pick_letter();
            end
            put_byte(CHAR_SEMI);
        end else if (kind < 60) begin
            // free-form lookahead, up to past its length
            put_byte(CHAR_AMP);
            n = $urandom_range(0, LOOKAHEAD + 2);
            repeat (n) put_byte(lookahead_byte());
        end else if (kind < 83) begin
            // multi-byte sequence; the short ones end the string
            n = $urandom_range(2, 4);
            b = 8'($urandom());
            case (n)
                2: put_byte({3'b110, b[4:0]});
                3: put_byte({4'b1110, b[3:0]});
                default: put_byte({5'b11110, b[2:0]});
            endcase
            if (kind < 75) begin
                conts = n - 1;
            end else begin
                conts    = $urandom_range(0, n - 2);
                unit_eos = 1'b1;
            end
            repeat (conts) begin
                b = 8'($urandom());
                put_byte(($urandom_range(0, 9) == 0) ? b : {2'b10, b[5:0]});
            end
        end else if (kind < 90) begin
            // invalid lead byte
            if ($urandom_range(0, 1) == 1) begin
                put_byte(8'($urandom_range(8'h80, 8'hBF)));
            end else begin
                put_byte(8'($urandom_range(8'hF8, 8'hFF)));
            end
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) put_byte(8'($urandom()));
        end
        // word start mostly on the first byte, sometimes stray inside
        foreach (unit_bytes[i]) begin
            unit_ws.insert(unit_ws.size(),
                           (i == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) == 0));
        end
    endfunction

    task automatic send_unit();
        foreach (unit_bytes[i]) begin
            send_byte(unit_bytes[i], unit_ws[i], unit_eos && (i == unit_bytes.size() - 1));
        end
    endtask

    task automatic run_phase(logic [1:0] mode, int style);
        set_case(mode);
        phase_bytes = 0;
        if (style == PHASE_HOLD) begin
            // keep offering bytes back to back while the output is held off
            hold_req  = 1'b1;
            tx_no_gap = 1'b1;
            while (hold_req || hold_active) begin
                build_unit();
                send_unit();
            end
            tx_no_gap = 1'b0;
        end
        if (style == PHASE_QUIET) begin
            rx_quiet  = 1'b1;
            tx_no_gap = 1'b1;
        end
        while (phase_bytes < PHASE_BYTES) begin
            build_unit();
            send_unit();
            // quiet stretch covers the first half of the phase
            if (phase_bytes >= PHASE_BYTES / 2) begin
                rx_quiet  = 1'b0;
                tx_no_gap = 1'b0;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening under the reset case mode
        foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8], opening[i][9]);

        // random phases, one per case mode, the last with a random mode
        run_phase(CASE_UPPER, PHASE_PLAIN);
        run_phase(CASE_LOWER, PHASE_PLAIN);
        run_phase(CASE_CAPITAL, PHASE_HOLD);
        run_phase(CASE_NONE, PHASE_QUIET);
        run_phase(2'($urandom_range(0, 3)), PHASE_PLAIN);

        wait_settled();
        $display("sent %0d text bytes, checked %0d code points, %0d case mode writes",
                 bytes_sent, checked, case_writes);
        $display({"mix: words, entity names good and spoiled, long lookaheads, utf-8 of 1 to 4",
                  " bytes, cut and invalid sequences, long output hold-off"});
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
